// ===== sv/tem_pkg.sv =====
package tem_pkg;

    localparam int unsigned WordBits = 32;
    localparam int unsigned FracBits = 16;
    localparam int unsigned CordicSteps = 30;
    localparam int unsigned ZBits = 34;

    localparam logic [63:0] PiQ61 = 64'h6487ED5110B4611A;
    localparam logic signed [ZBits-1:0] CordicGain = 34'sd652032874;

    function automatic logic signed [ZBits-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZBits-1:0] res;
        case (idx)
            5'd0: res = 34'sh3243F6A8;
            5'd1: res = 34'sh1DAC6705;
            5'd2: res = 34'sh0FADBAFC;
            5'd3: res = 34'sh07F56EA6;
            5'd4: res = 34'sh03FEAB76;
            5'd5: res = 34'sh01FFD55B;
            5'd6: res = 34'sh00FFFAAA;
            5'd7: res = 34'sh007FFF55;
            5'd8: res = 34'sh003FFFEA;
            5'd9: res = 34'sh001FFFFD;
            default: res = (34'sh1 <<< (5'd30 - idx)) - 34'sh1;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/tem_fmul.sv =====
module tem_fmul
    import tem_pkg::*;
#(
    parameter int unsigned WORD_BITS = WordBits,
    parameter int unsigned FRAC_BITS = FracBits
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_a,
    input  logic signed [WORD_BITS-1:0] i_b,
    output logic signed [WORD_BITS-1:0] o_p
);

    localparam int unsigned PBits = 2 * WORD_BITS + 1;

    logic signed [PBits-1:0] r_prod;
    logic signed [PBits-1:0] n_prod;
    logic        [PBits-1:0] w_mag;
    logic        [PBits-1:0] w_rnd;
    logic        [PBits-1:0] w_q;
    logic        [PBits-1:0] w_lim;
    logic                    w_neg;
    logic signed [WORD_BITS-1:0] n_p;

    assign n_prod = PBits'(i_a) * PBits'(i_b);
    assign w_neg  = r_prod[PBits-1];
    assign w_mag  = w_neg ? PBits'(-r_prod) : PBits'(r_prod);
    assign w_rnd  = w_mag + (PBits'(1) << (FRAC_BITS - 1));
    assign w_q    = w_rnd >> FRAC_BITS;
    assign w_lim  = w_neg ? (PBits'(1) << (WORD_BITS - 1))
                          : ((PBits'(1) << (WORD_BITS - 1)) - PBits'(1));

    always_comb begin
        if (w_q > w_lim) begin
            n_p = w_neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        end else begin
            n_p = w_neg ? WORD_BITS'(-w_q) : WORD_BITS'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            o_p    <= n_p;
        end
    end

endmodule

// ===== sv/twist_exponential_map.sv =====
// Streaming SE(3) exponential map. One twist may be offered every clock cycle
// while o_ready is high, and each transaction yields exactly one transform
// through the pipeline: angle reduction, a 30-stage unrolled CORDIC
// for sine and cosine, then registered product and saturating-sum stages for
// the rotation and the translation. Every product takes two stages and every
// sum is saturated to the word. Back-pressure on the output stalls the whole
// pipeline without losing or repeating a transaction.
module twist_exponential_map
    import tem_pkg::*;
#(
    parameter int unsigned WORD_BITS = WordBits,
    parameter int unsigned FRAC_BITS = FracBits
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [31:0]          i_lin_x,
    input  logic signed [31:0]          i_lin_y,
    input  logic signed [31:0]          i_lin_z,
    input  logic signed [31:0]          i_ang_x,
    input  logic signed [31:0]          i_ang_y,
    input  logic signed [31:0]          i_ang_z,
    input  logic signed [31:0]          i_angle,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [WORD_BITS-1:0] o_rot_00,
    output logic signed [WORD_BITS-1:0] o_rot_01,
    output logic signed [WORD_BITS-1:0] o_rot_02,
    output logic signed [WORD_BITS-1:0] o_rot_10,
    output logic signed [WORD_BITS-1:0] o_rot_11,
    output logic signed [WORD_BITS-1:0] o_rot_12,
    output logic signed [WORD_BITS-1:0] o_rot_20,
    output logic signed [WORD_BITS-1:0] o_rot_21,
    output logic signed [WORD_BITS-1:0] o_rot_22,
    output logic signed [WORD_BITS-1:0] o_pos_x,
    output logic signed [WORD_BITS-1:0] o_pos_y,
    output logic signed [WORD_BITS-1:0] o_pos_z
);

    localparam int unsigned W = WORD_BITS;
    localparam int unsigned ShQ = 30 - FRAC_BITS;
    localparam logic [63:0] PiQ = ((PiQ61 >> (60 - FRAC_BITS)) + 64'd1) >> 1;
    localparam logic [63:0] TwoPiQ = ((PiQ61 >> (59 - FRAC_BITS)) + 64'd1) >> 1;
    localparam logic signed [W:0] SMax = (W+1)'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [W:0] SMin = -SMax - (W+1)'(1);
    localparam logic signed [W-1:0] One = (FRAC_BITS < W - 1) ?
        W'(64'd1 << FRAC_BITS) : W'((64'd1 << (W - 1)) - 64'd1);
    localparam int unsigned CS = CordicSteps;
    localparam int unsigned Lat = 49;

    typedef logic signed [W-1:0] t_word;
    typedef logic signed [ZBits-1:0] t_cw;

    function automatic t_word sat1(input logic signed [W+1:0] v);
        t_word res;
        if (v > (W+2)'(SMax)) begin
            res = t_word'(SMax);
        end else if (v < (W+2)'(SMin)) begin
            res = t_word'(SMin);
        end else begin
            res = t_word'(v);
        end
        return res;
    endfunction

    function automatic t_word sadd(input t_word a, input t_word b);
        return sat1((W+2)'(a) + (W+2)'(b));
    endfunction

    function automatic t_word ssub(input t_word a, input t_word b);
        return sat1((W+2)'(a) - (W+2)'(b));
    endfunction

    function automatic t_word sneg(input t_word a);
        return sat1(-(W+2)'(a));
    endfunction

    logic w_en;
    logic [Lat-1:0] r_vld;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
        end
    end

    // Delay lines for operands that are needed later.
    t_word r_v [Lat][3];
    t_word r_w [Lat][3];
    t_word r_th [Lat];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v[0][0] <= t_word'(i_lin_x);
            r_v[0][1] <= t_word'(i_lin_y);
            r_v[0][2] <= t_word'(i_lin_z);
            r_w[0][0] <= t_word'(i_ang_x);
            r_w[0][1] <= t_word'(i_ang_y);
            r_w[0][2] <= t_word'(i_ang_z);
            r_th[0]   <= t_word'(i_angle);
            for (int k = 1; k < Lat; k++) begin
                r_v[k] <= r_v[k-1];
                r_w[k] <= r_w[k-1];
                r_th[k] <= r_th[k-1];
            end
        end
    end

    // Angle reduction: theta is reduced with a reciprocal multiply and a correction.
    localparam int unsigned RBits = W + 2;
    localparam int unsigned RecBits = W + 4;
    localparam logic [2*RecBits-1:0] Recip =
        ((2*RecBits)'(1) << (RecBits + FRAC_BITS - 2)) / (2*RecBits)'(TwoPiQ);
    typedef logic signed [RBits-1:0] t_r;

    logic [RecBits+W:0] r_qp;
    logic               r_tneg;
    t_r                 r_rem;
    t_r                 r_red;
    logic               r_flip;
    logic [W-1:0]       w_tmag;
    logic [W+RecBits:0] w_qraw;
    logic [W:0]         w_q;
    logic signed [W+RecBits+1:0] w_rm;
    t_r                 w_rem;
    t_r                 w_r;
    logic               w_fl;

    assign w_tmag = r_th[0][W-1] ? W'(-r_th[0]) : W'(r_th[0]);
    assign w_qraw = (W+RecBits+1)'(w_tmag) * (W+RecBits+1)'(Recip[RecBits-1:0]);
    assign w_q = (W+1)'(r_qp >> (RecBits + FRAC_BITS - 2));
    assign w_rm = (W+RecBits+2)'(r_th[1] < 0 ? -(W+2)'(r_th[1]) : (W+2)'(r_th[1]))
                - (W+RecBits+2)'(w_q) * (W+RecBits+2)'(TwoPiQ);

    always_comb begin
        w_rem = t_r'(w_rm);
        if (w_rem >= t_r'(TwoPiQ)) begin
            w_rem = w_rem - t_r'(TwoPiQ);
        end
        if (w_rem < 0) begin
            w_rem = w_rem + t_r'(TwoPiQ);
        end
    end

    always_comb begin
        w_r  = r_rem;
        w_fl = 1'b0;
        if (w_r > t_r'(PiQ)) begin
            w_r = w_r - t_r'(TwoPiQ);
        end
        if (w_r > t_r'(PiQ >> 1)) begin
            w_r  = w_r - t_r'(PiQ);
            w_fl = 1'b1;
        end else if (w_r < -t_r'(PiQ >> 1)) begin
            w_r  = w_r + t_r'(PiQ);
            w_fl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qp   <= w_qraw;
            r_tneg <= r_th[0][W-1];
            r_rem  <= r_tneg && (w_rem != 0) ? t_r'(TwoPiQ) - w_rem : w_rem;
            r_red  <= w_r;
            r_flip <= w_fl;
        end
    end

    // CORDIC pipeline, one rotation per stage.
    t_cw  r_cx [CS+1];
    t_cw  r_cy [CS+1];
    t_cw  r_cz [CS+1];
    logic r_cf [CS+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx[0] <= CordicGain;
            r_cy[0] <= '0;
            r_cz[0] <= ZBits'(r_red) <<< ShQ;
            r_cf[0] <= r_flip;
            for (int k = 0; k < CS; k++) begin
                if (r_cz[k] >= 0) begin
                    r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                    r_cz[k+1] <= r_cz[k] - atan_q30(5'(k));
                end else begin
                    r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                    r_cz[k+1] <= r_cz[k] + atan_q30(5'(k));
                end
                r_cf[k+1] <= r_cf[k];
            end
        end
    end

    function automatic t_word from_q30(input t_cw v);
        logic signed [ZBits:0] t;
        t = (ZBits+1)'(v);
        if (ShQ > 0) begin
            t = (t + ((ZBits+1)'(1) <<< (ShQ - 1))) >>> ShQ;
        end
        return sat1((W+2)'(t));
    endfunction

    // Stage 35: sine and cosine, then one minus cosine in the register after.
    localparam int unsigned S0 = 35;
    t_word r_sn;
    t_word r_cs;
    t_word r_c1;
    t_word w_sn;
    t_word w_cs;

    assign w_sn = r_cf[CS] ? sneg(from_q30(r_cy[CS])) : from_q30(r_cy[CS]);
    assign w_cs = r_cf[CS] ? sneg(from_q30(r_cx[CS])) : from_q30(r_cx[CS]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sn <= w_sn;
            r_cs <= w_cs;
            r_c1 <= ssub(One, r_cs);
        end
    end

    // Products of the axis with itself and with v, and of v with theta, in parallel with CORDIC.
    t_word w_ww [3][3];
    t_word w_wv [3][3];
    t_word w_vt [3];

    for (genvar i = 0; i < 3; i++) begin : g_wp
        for (genvar j = 0; j < 3; j++) begin : g_wq
            tem_fmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_ww (
                .i_clk(i_clk), .i_en(w_en), .i_a(r_w[0][i]), .i_b(r_w[0][j]),
                .o_p(w_ww[i][j]));
            tem_fmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_wv (
                .i_clk(i_clk), .i_en(w_en), .i_a(r_w[0][i]), .i_b(r_v[0][j]),
                .o_p(w_wv[i][j]));
        end
        tem_fmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_vt (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_v[0][i]), .i_b(r_th[0]),
            .o_p(w_vt[i]));
    end

    // Stage 3: square of the skew matrix, cross product, dot partial.
    t_word r_sq [3][3];
    t_word r_cr [3];
    t_word r_d01;
    t_word r_wz;
    t_word r_vt [Lat][3];
    t_word r_sqd [Lat][3][3];
    t_word r_crd [Lat][3];
    t_word r_dot;
    t_word r_dotd [Lat];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (i == j) begin
                        r_sq[i][j] <= sneg(sadd(w_ww[(i+1)%3][(i+1)%3],
                                                w_ww[(i+2)%3][(i+2)%3]));
                    end else begin
                        r_sq[i][j] <= w_ww[i][j];
                    end
                end
                r_vt[3][i] <= w_vt[i];
            end
            r_cr[0] <= ssub(w_wv[1][2], w_wv[2][1]);
            r_cr[1] <= ssub(w_wv[2][0], w_wv[0][2]);
            r_cr[2] <= ssub(w_wv[0][1], w_wv[1][0]);
            r_d01   <= sadd(w_wv[0][0], w_wv[1][1]);
            r_wz    <= w_wv[2][2];
            r_dot   <= sadd(r_d01, r_wz);
            r_sqd[3] <= r_sq;
            r_crd[3] <= r_cr;
            r_dotd[4] <= r_dot;
            for (int k = 4; k < Lat; k++) begin
                r_vt[k] <= r_vt[k-1];
                r_sqd[k] <= r_sqd[k-1];
                r_crd[k] <= r_crd[k-1];
            end
            for (int k = 5; k < Lat; k++) begin
                r_dotd[k] <= r_dotd[k-1];
            end
        end
    end

    // Rotation: products at stages 36 to 38, sums at 38 and 39.
    t_word w_ps [3][3];
    t_word w_pc [3][3];
    t_word w_skw [3][3];
    t_word r_pre [3][3];
    t_word r_rot [3][3];
    t_word w_dt;

    always_comb begin
        w_skw[0][0] = '0;
        w_skw[0][1] = sneg(r_w[S0][2]);
        w_skw[0][2] = r_w[S0][1];
        w_skw[1][0] = r_w[S0][2];
        w_skw[1][1] = '0;
        w_skw[1][2] = sneg(r_w[S0][0]);
        w_skw[2][0] = sneg(r_w[S0][1]);
        w_skw[2][1] = r_w[S0][0];
        w_skw[2][2] = '0;
    end

    for (genvar i = 0; i < 3; i++) begin : g_rp
        for (genvar j = 0; j < 3; j++) begin : g_rq
            tem_fmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_ps (
                .i_clk(i_clk), .i_en(w_en), .i_a(r_sn), .i_b(w_skw[i][j]),
                .o_p(w_ps[i][j]));
            tem_fmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_pc (
                .i_clk(i_clk), .i_en(w_en), .i_a(r_c1), .i_b(r_sqd[S0][i][j]),
                .o_p(w_pc[i][j]));
        end
    end

    tem_fmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_dt (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_dotd[S0]), .i_b(r_th[S0+1]), .o_p(w_dt));

    t_word r_dt [Lat];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pre[i][j] <= sadd((i == j) ? One : t_word'(0), w_ps[i][j]);
                    r_rot[i][j] <= sadd(r_pre[i][j], w_pc[i][j]);
                end
            end
            r_dt[S0+3] <= w_dt;
            for (int k = S0 + 4; k < Lat; k++) begin
                r_dt[k] <= r_dt[k-1];
            end
        end
    end

    // Translation: rotation and axis products, then the chain of saturating sums.
    localparam int unsigned S1 = S0 + 4;
    t_word w_rc [3][3];
    t_word w_wd [3];
    t_word r_rotd [Lat][3][3];
    t_word r_a0 [3];
    t_word r_a1 [3];
    t_word r_a2 [3];
    t_word r_a3 [3];
    t_word r_a4 [3];
    t_word r_pc [3][3];
    t_word r_pw [3];
    t_word r_pc2 [3];
    t_word r_pw2 [3];
    t_word r_pw3 [3];

    for (genvar i = 0; i < 3; i++) begin : g_tp
        for (genvar j = 0; j < 3; j++) begin : g_tq
            tem_fmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_rc (
                .i_clk(i_clk), .i_en(w_en), .i_a(r_rotd[S1+1][i][j]),
                .i_b(r_crd[S1][j]), .o_p(w_rc[i][j]));
        end
        tem_fmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_wd (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_w[S1+1][i]), .i_b(r_dt[S1]),
            .o_p(w_wd[i]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rotd[S1+1] <= r_rot;
            for (int k = S1 + 2; k < Lat; k++) begin
                r_rotd[k] <= r_rotd[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_pc[i] <= w_rc[i];
                r_pw[i] <= w_wd[i];
                r_a0[i] <= ssub(r_crd[S1+2][i], w_rc[i][0]);
                r_a1[i] <= ssub(r_a0[i], r_pc[i][1]);
                r_a2[i] <= ssub(r_a1[i], r_pc2[i]);
                r_a3[i] <= sadd(r_a2[i], r_pw3[i]);
                r_a4[i] <= r_a3[i];
            end
        end
    end

    // Delay registers carry the products forward to the later sums that consume them.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pc2[i] <= r_pc[i][2];
                r_pw2[i] <= r_pw[i];
                r_pw3[i] <= r_pw2[i];
            end
        end
    end

    t_word r_out_rot [3][3];
    t_word r_out_pos [3];
    logic  w_zero;

    assign w_zero = (r_w[Lat-2][0] == 0) && (r_w[Lat-2][1] == 0) && (r_w[Lat-2][2] == 0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_out_pos[i] <= w_zero ? r_vt[Lat-2][i] : r_a4[i];
            end
            r_out_rot <= r_rotd[Lat-2];
        end
    end

    assign o_rot_00 = r_out_rot[0][0];
    assign o_rot_01 = r_out_rot[0][1];
    assign o_rot_02 = r_out_rot[0][2];
    assign o_rot_10 = r_out_rot[1][0];
    assign o_rot_11 = r_out_rot[1][1];
    assign o_rot_12 = r_out_rot[1][2];
    assign o_rot_20 = r_out_rot[2][0];
    assign o_rot_21 = r_out_rot[2][1];
    assign o_rot_22 = r_out_rot[2][2];
    assign o_pos_x  = r_out_pos[0];
    assign o_pos_y  = r_out_pos[1];
    assign o_pos_z  = r_out_pos[2];

endmodule
